@@ hdl/tile_height_quantizer_top_macros.svh @@
// Assertion macros for the tile height quantiser checker
`ifndef TILE_HEIGHT_QUANTIZER_TOP_MACROS_SVH
`define TILE_HEIGHT_QUANTIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define THQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define THQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/thq_pkg.sv @@
// Shared constants and widths for the tile height quantiser
package thq_pkg;

	localparam int SAMPLE_COUNT = 4096;
	localparam int FRAC_BITS    = 8;

	localparam int HEIGHT_W = 32;
	localparam int BOUND_W  = 24;
	localparam int CODE_W   = 16;

	localparam int IDX_W  = $clog2(SAMPLE_COUNT);
	localparam int SPAN_W = BOUND_W + FRAC_BITS;
	localparam int DIFF_W = ((HEIGHT_W > SPAN_W) ? HEIGHT_W : SPAN_W) + 2;
	localparam int DEN_W  = SPAN_W + 1;
	localparam int NUM_W  = SPAN_W + CODE_W + 2;
	localparam int CNT_W  = $clog2(CODE_W);
	localparam int EXT_W  = HEIGHT_W + 2;

	localparam int BOUND_MAX = 2 ** (BOUND_W - 1) - 1;
	localparam int BOUND_MIN = -(2 ** (BOUND_W - 1));

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic KIND_BOUNDS = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

endpackage

@@ hdl/thq_in_if.sv @@
// Command channel: load a sample or request the next code
interface thq_in_if import thq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic signed [HEIGHT_W-1:0] height;

	modport source (output valid, cmd, height, input ready);
	modport sink   (input valid, cmd, height, output ready);
endinterface

@@ hdl/thq_out_if.sv @@
// Result channel: tile bounds or a quantised sample
interface thq_out_if import thq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [BOUND_W-1:0] low_metres;
	logic signed [BOUND_W-1:0] high_metres;
	logic        [CODE_W-1:0]  code;
	logic                      last_of_tile;

	modport source (output valid, kind, low_metres, high_metres, code, last_of_tile,
		input ready);
	modport sink   (input valid, kind, low_metres, high_metres, code, last_of_tile,
		output ready);
endinterface

@@ hdl/thq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data
module thq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hdl/tile_height_quantizer_top.sv @@
// Tile height quantiser: bounds tracking and 16-bit requantisation of one tile
//
//  channel  dir  payload                                          transfer
//  sample   in   cmd, height                                      valid && ready
//  result   out  kind, low_metres, high_metres, code, last_of_tile valid && ready
//
// A load is taken in the idle state; the final load of a tile passes the bounds and emit states.
// A readout steps through the store read, the offset and the numerator, then the restoring
// divider by twice the tile span at one bit per cycle; a clamped code skips the last two steps.
// The sample store holds no reset and needs no clearing pass: readout only follows a full load.
// A finished result waits in the output register; the next command is taken meanwhile,
// and only a further result stalls until the output register is free.
module tile_height_quantizer_top import thq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	thq_in_if.sink      sample,
	thq_out_if.source   result
);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CODE_W - 1);
	localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(BOUND_MAX);
	localparam logic signed [EXT_W-1:0] SAT_MIN = EXT_W'(BOUND_MIN);
	localparam logic signed [EXT_W-1:0] CEIL_ADD = EXT_W'((1 << FRAC_BITS) - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOUNDS,
		ST_DIFF,
		ST_NUM,
		ST_DIV,
		ST_EMIT
	} state_t;

	function automatic logic signed [BOUND_W-1:0] sat_bound(input logic signed [EXT_W-1:0] v);
		logic signed [BOUND_W-1:0] r;
		if (v > SAT_MAX) begin
			r = BOUND_W'(BOUND_MAX);
		end else if (v < SAT_MIN) begin
			r = BOUND_W'(BOUND_MIN);
		end else begin
			r = v[BOUND_W-1:0];
		end
		return r;
	endfunction

	state_t                     state_q;
	logic                       phase_q;   // 1 while the tile is being read out
	logic [IDX_W-1:0]           idx_q;
	logic signed [HEIGHT_W-1:0] min_q;
	logic signed [HEIGHT_W-1:0] max_q;
	logic signed [BOUND_W-1:0]  low_q;
	logic signed [BOUND_W-1:0]  high_q;
	logic [SPAN_W-1:0]          span_q;
	logic [SPAN_W-1:0]          diff_q;
	logic [DEN_W-1:0]           rem_q;
	logic [CODE_W-1:0]          quot_q;
	logic [CNT_W-1:0]           step_q;
	logic                       kind_q;
	logic                       last_q;

	logic                       out_valid_q;
	logic                       out_kind_q;
	logic signed [BOUND_W-1:0]  out_low_q;
	logic signed [BOUND_W-1:0]  out_high_q;
	logic [CODE_W-1:0]          out_code_q;
	logic                       out_last_q;

	logic                       in_fire;
	logic                       emit_fire;
	logic                       ram_we;
	logic                       ram_re;
	logic [HEIGHT_W-1:0]        ram_rdata;
	logic signed [HEIGHT_W-1:0] rd_height;

	logic signed [EXT_W-1:0]    min_ext;
	logic signed [EXT_W-1:0]    max_ext;
	logic signed [BOUND_W-1:0]  low_new;
	logic signed [BOUND_W-1:0]  high_new;
	logic [BOUND_W:0]           range_w;
	logic [SPAN_W-1:0]          span_new;

	logic signed [DIFF_W-1:0]   h_ext;
	logic signed [DIFF_W-1:0]   low_fx;
	logic signed [DIFF_W-1:0]   span_ext;
	logic signed [DIFF_W-1:0]   diff;

	logic [NUM_W-1:0]           num;
	logic [DEN_W-1:0]           den;
	logic [DEN_W:0]             trial;
	logic                       trial_ge;
	logic [DEN_W:0]             trial_sub;

	assign sample.ready = (state_q == ST_IDLE);
	assign in_fire      = sample.valid && sample.ready;
	assign ram_we       = in_fire && !phase_q && (sample.cmd == CMD_LOAD);
	assign ram_re       = in_fire && phase_q && (sample.cmd == CMD_READ);
	// output register is free or empties at this edge
	assign emit_fire    = (state_q == ST_EMIT) && (!out_valid_q || result.ready);

	// Loading and readout never overlap, so no forwarding between write and read
	thq_ram #(
		.WIDTH (HEIGHT_W),
		.DEPTH (SAMPLE_COUNT)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (sample.height),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign rd_height = ram_rdata;

	// Floor of the minimum, ceiling of the maximum, saturated to the bound width
	assign min_ext  = EXT_W'(min_q);
	assign max_ext  = EXT_W'(max_q);
	assign low_new  = sat_bound(min_ext >>> FRAC_BITS);
	assign high_new = sat_bound((max_ext + CEIL_ADD) >>> FRAC_BITS);

	assign range_w  = {high_q[BOUND_W-1], high_q} - {low_q[BOUND_W-1], low_q};
	assign span_new = SPAN_W'(range_w[BOUND_W-1:0]) << FRAC_BITS;

	assign h_ext    = DIFF_W'(rd_height);
	assign low_fx   = DIFF_W'(low_q) <<< FRAC_BITS;
	assign span_ext = DIFF_W'(span_q);
	assign diff     = h_ext - low_fx;

	// 2*diff*65535 + span, as shifts and adds
	assign num = (NUM_W'(diff_q) << (CODE_W + 1)) - (NUM_W'(diff_q) << 1) + NUM_W'(span_q);
	assign den = {span_q, 1'b0};

	assign trial     = {rem_q, quot_q[CODE_W-1]};
	assign trial_ge  = (trial >= {1'b0, den});
	assign trial_sub = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			idx_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			low_q       <= '0;
			high_q      <= '0;
			span_q      <= '0;
			diff_q      <= '0;
			rem_q       <= '0;
			quot_q      <= '0;
			step_q      <= '0;
			kind_q      <= KIND_BOUNDS;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_BOUNDS;
			out_low_q   <= '0;
			out_high_q  <= '0;
			out_code_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (ram_we) begin
						if (idx_q == '0) begin
							min_q <= sample.height;
							max_q <= sample.height;
						end else begin
							if (sample.height < min_q) begin
								min_q <= sample.height;
							end
							if (sample.height > max_q) begin
								max_q <= sample.height;
							end
						end
						if (idx_q == LAST_IDX) begin
							idx_q   <= '0;
							phase_q <= 1'b1;
							state_q <= ST_BOUNDS;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else if (ram_re) begin
						last_q <= (idx_q == LAST_IDX);
						if (idx_q == LAST_IDX) begin
							idx_q   <= '0;
							phase_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
						state_q <= ST_DIFF;
					end
				end

				ST_BOUNDS: begin
					low_q   <= low_new;
					high_q  <= high_new;
					kind_q  <= KIND_BOUNDS;
					quot_q  <= '0;
					last_q  <= 1'b0;
					state_q <= ST_EMIT;
				end

				ST_DIFF: begin
					kind_q <= KIND_SAMPLE;
					if ((span_q == '0) || (diff <= 0)) begin
						quot_q  <= '0;
						state_q <= ST_EMIT;
					end else if (diff >= span_ext) begin
						quot_q  <= '1;
						state_q <= ST_EMIT;
					end else begin
						diff_q  <= diff[SPAN_W-1:0];
						state_q <= ST_NUM;
					end
				end

				ST_NUM: begin
					// top part is below the divisor since diff < span
					rem_q   <= num[CODE_W+DEN_W-1:CODE_W];
					quot_q  <= num[CODE_W-1:0];
					step_q  <= '0;
					state_q <= ST_DIV;
				end

				ST_DIV: begin
					if (trial_ge) begin
						rem_q <= trial_sub[DEN_W-1:0];
					end else begin
						rem_q <= trial[DEN_W-1:0];
					end
					quot_q <= {quot_q[CODE_W-2:0], trial_ge};
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_EMIT;
					end
				end

				ST_EMIT: begin
					if (emit_fire) begin
						out_kind_q  <= kind_q;
						out_low_q   <= low_q;
						out_high_q  <= high_q;
						out_code_q  <= quot_q;
						out_last_q  <= last_q;
						if (kind_q == KIND_BOUNDS) begin
							span_q <= span_new;
						end
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.kind         = out_kind_q;
	assign result.low_metres   = out_low_q;
	assign result.high_metres  = out_high_q;
	assign result.code         = out_code_q;
	assign result.last_of_tile = out_last_q;
endmodule

@@ hdl/thq_checker.sv @@
// Port-level checks on the tile height quantiser result channel, bound to the top level
`include "tile_height_quantizer_top_macros.svh"

module thq_checker import thq_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      out_kind,
	input logic signed [BOUND_W-1:0] out_low,
	input logic signed [BOUND_W-1:0] out_high,
	input logic [CODE_W-1:0]         out_code,
	input logic                      out_last
);
	logic                bounds_shown;
	logic                bounds_blank;
	logic                code_shown;
	logic                stalled;
	logic [CODE_W+1:0]   out_bits;

	assign bounds_shown = out_valid && (out_kind == KIND_BOUNDS);
	assign bounds_blank = (out_code == '0) && !out_last;
	assign code_shown   = out_valid && (out_kind == KIND_SAMPLE) && (out_code != '0);
	assign stalled      = out_valid && !out_ready;
	assign out_bits     = {out_kind, out_code, out_last};

	`THQ_ASSERT_NOW(a_bounds_ordered, clk, arst_n, out_valid, out_low <= out_high, "low above high")
	`THQ_ASSERT_NOW(a_bounds_clean, clk, arst_n, bounds_shown, bounds_blank, "bounds not blank")
	`THQ_ASSERT_NOW(a_flat_tile_zero, clk, arst_n, code_shown, out_high != out_low, "code on flat tile")
	`THQ_ASSERT_NEXT(a_result_held, clk, arst_n, stalled, out_valid && $stable(out_bits), "result moved")
endmodule

bind tile_height_quantizer_top thq_checker u_thq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_kind  (result.kind),
	.out_low   (result.low_metres),
	.out_high  (result.high_metres),
	.out_code  (result.code),
	.out_last  (result.last_of_tile)
);

@@ tb/sv/tb_tile_height_quantizer_top.sv @@
// Self-checking testbench for the tile height quantiser: directed tiles, then random tiles
`timescale 1ns / 100ps

module tb_tile_height_quantizer_top;
	import thq_pkg::*;

	localparam longint CODE_MAX     = (longint'(1) << CODE_W) - 1;
	localparam longint HEIGHT_MAX   = (longint'(1) << (HEIGHT_W - 1)) - 1;
	localparam int     RANDOM_TILES = 2;
	localparam int     NOISE_ODDS   = 32;
	localparam int     HOLD_OFF     = 500;
	localparam int     STALL_LIMIT  = 4000;
	localparam int     DRAIN_CYCLES = 40;
	localparam int     MAX_SHOWN    = 10;

	typedef struct packed {
		logic              kind;
		logic [BOUND_W-1:0] low_metres;
		logic [BOUND_W-1:0] high_metres;
		logic [CODE_W-1:0]  code;
		logic              last_of_tile;
	} height_result_t;

	typedef struct {
		logic               cmd;
		logic [HEIGHT_W-1:0] height;
		int                 reps;
		bit                 typed;
		bit                 typed_has;
		height_result_t     typed_res;
	} plan_row_t;

	logic clk;
	logic arst_n;

	thq_in_if  sample_ch ();
	thq_out_if result_ch ();

	tile_height_quantizer_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// predictor state
	logic signed [HEIGHT_W-1:0] stored_heights [SAMPLE_COUNT];
	longint low_seen, high_seen, tile_low, tile_high;
	int     loads_taken, read_pos;
	bit     reading_out;

	height_result_t tile_results [$];
	plan_row_t      plan [$];
	int             fault_count;
	int             results_seen;
	int             send_calm, recv_calm;

	function automatic longint sat_bound(input longint v);
		if (v > BOUND_MAX) return BOUND_MAX;
		if (v < BOUND_MIN) return BOUND_MIN;
		return v;
	endfunction

	// one accepted command; returns 1 when it gives a result
	function automatic bit tile_step(input logic c, input logic signed [HEIGHT_W-1:0] h,
			output height_result_t r);
		longint hv, one, span, diff;
		bit     last;
		r = '0;
		one = longint'(1) << FRAC_BITS;
		if (!reading_out) begin
			if (c != CMD_LOAD) return 1'b0;
			hv = h;
			if (loads_taken < SAMPLE_COUNT) stored_heights[loads_taken] = h;
			if (loads_taken == 0) begin
				low_seen = hv;
				high_seen = hv;
			end else begin
				if (hv < low_seen) low_seen = hv;
				if (hv > high_seen) high_seen = hv;
			end
			loads_taken++;
			if (loads_taken < SAMPLE_COUNT) return 1'b0;
			tile_low = sat_bound(low_seen >>> FRAC_BITS);
			tile_high = sat_bound(-((-high_seen) >>> FRAC_BITS));
			reading_out = 1'b1;
			read_pos = 0;
			r.kind = KIND_BOUNDS;
			r.low_metres = BOUND_W'(tile_low);
			r.high_metres = BOUND_W'(tile_high);
			return 1'b1;
		end
		if (c != CMD_READ) return 1'b0;
		hv = stored_heights[read_pos];
		span = (tile_high - tile_low) * one;
		diff = hv - tile_low * one;
		last = (read_pos == SAMPLE_COUNT - 1);
		r.kind = KIND_SAMPLE;
		r.low_metres = BOUND_W'(tile_low);
		r.high_metres = BOUND_W'(tile_high);
		if (span <= 0 || diff <= 0)
			r.code = '0;
		else if (diff >= span)
			r.code = CODE_W'(CODE_MAX);
		else
			r.code = CODE_W'((2 * diff * CODE_MAX + span) / (2 * span));
		r.last_of_tile = last;
		if (last) begin
			reading_out = 1'b0;
			loads_taken = 0;
			read_pos = 0;
		end else begin
			read_pos++;
		end
		return 1'b1;
	endfunction

	function automatic height_result_t mk_result(input logic kind, input int lo, input int hi,
			input int code, input logic last);
		height_result_t r;
		r.kind = kind;
		r.low_metres = BOUND_W'(lo);
		r.high_metres = BOUND_W'(hi);
		r.code = CODE_W'(code);
		r.last_of_tile = last;
		return r;
	endfunction

	function automatic void plan_add(input logic c, input logic [HEIGHT_W-1:0] h, input int reps,
			input bit typed, input bit typed_has, input height_result_t res);
		plan_row_t row;
		row.cmd = c;
		row.height = h;
		row.reps = reps;
		row.typed = typed;
		row.typed_has = typed_has;
		row.typed_res = res;
		plan.insert(plan.size(), row);
	endfunction

	// mostly short gaps, a few long ones, and now and then a stretch with none
	function automatic int pick_gap(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 199) == 0) calm = $urandom_range(40, 300);
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [HEIGHT_W-1:0] pick_height(input int style,
			input logic [HEIGHT_W-1:0] centre, input int spread);
		longint v;
		if (style == 0 || (style == 2 && $urandom_range(0, 63) == 0)) return $urandom;
		v = longint'($signed(centre)) + $urandom_range(0, spread);
		if (v > HEIGHT_MAX) v = HEIGHT_MAX;
		return HEIGHT_W'(v);
	endfunction

	task automatic offer(input logic c, input logic [HEIGHT_W-1:0] h, input bit typed,
			input bit typed_has, input height_result_t typed_res);
		height_result_t r;
		bit             has;
		int             gap;
		sample_ch.valid <= 1'b1;
		sample_ch.cmd <= c;
		sample_ch.height <= h;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		has = tile_step(c, h, r);
		if (typed) begin
			has = typed_has;
			r = typed_res;
		end
		if (has) tile_results.insert(tile_results.size(), r);
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_results_drained();
		sample_ch.valid <= 1'b0;
		while (tile_results.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int                  style, spread, loads, reads, pause_at;
		logic [HEIGHT_W-1:0] centre;
		fault_count = 0;
		send_calm = 0;
		reading_out = 1'b0;
		loads_taken = 0;
		read_pos = 0;
		low_seen = 0;
		high_seen = 0;
		tile_low = 0;
		tile_high = 0;
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.cmd <= CMD_LOAD;
		sample_ch.height <= '0;

		// tile of extremes: both bounds at or past the 24-bit limits
		plan_add(CMD_READ, 0, 1, 1, 0, '0);
		plan_add(CMD_LOAD, 32'h7FFF_FFFF, 1, 0, 0, '0);
		plan_add(CMD_LOAD, 32'h8000_0000, 1, 0, 0, '0);
		plan_add(CMD_LOAD, 32'h0000_0080, SAMPLE_COUNT - 4, 0, 0, '0);
		plan_add(CMD_LOAD, 32'hFFFF_FFFF, 1, 0, 0, '0);
		plan_add(CMD_LOAD, 0, 1, 1, 1, mk_result(KIND_BOUNDS, BOUND_MIN, BOUND_MAX, 0, 1'b0));
		plan_add(CMD_LOAD, 12345, 1, 1, 0, '0);
		plan_add(CMD_READ, 0, 1, 1, 1,
			mk_result(KIND_SAMPLE, BOUND_MIN, BOUND_MAX, int'(CODE_MAX), 1'b0));
		plan_add(CMD_READ, 0, 1, 1, 1, mk_result(KIND_SAMPLE, BOUND_MIN, BOUND_MAX, 0, 1'b0));
		plan_add(CMD_READ, 0, SAMPLE_COUNT - 3, 0, 0, '0);
		plan_add(CMD_READ, 0, 1, 0, 0, '0);
		// flat tile on a whole metre: zero span
		plan_add(CMD_LOAD, 5 << FRAC_BITS, SAMPLE_COUNT - 1, 0, 0, '0);
		plan_add(CMD_LOAD, 5 << FRAC_BITS, 1, 1, 1, mk_result(KIND_BOUNDS, 5, 5, 0, 1'b0));
		plan_add(CMD_READ, 0, SAMPLE_COUNT - 1, 0, 0, '0);
		plan_add(CMD_READ, 0, 1, 1, 1, mk_result(KIND_SAMPLE, 5, 5, 0, 1'b1));
		// negative fractional heights: floor and ceil both move
		plan_add(CMD_LOAD, -300, 1, 0, 0, '0);
		plan_add(CMD_LOAD, -200, SAMPLE_COUNT - 2, 0, 0, '0);
		plan_add(CMD_LOAD, -256, 1, 1, 1, mk_result(KIND_BOUNDS, -2, 0, 0, 1'b0));
		plan_add(CMD_READ, 0, SAMPLE_COUNT, 0, 0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			for (int k = 0; k < plan[i].reps; k++)
				offer(plan[i].cmd, plan[i].height, plan[i].typed, plan[i].typed_has,
					plan[i].typed_res);
		wait_results_drained();

		for (int t = 0; t < RANDOM_TILES; t++) begin
			style = (t == 0) ? 0 : $urandom_range(1, 2);
			centre = $signed($urandom) >>> $urandom_range(4, 31);
			spread = 1 << $urandom_range(0, 16);
			loads = 0;
			while (loads < SAMPLE_COUNT) begin
				if ($urandom_range(0, NOISE_ODDS - 1) == 0) begin
					offer(CMD_READ, $urandom, 0, 0, '0);
				end else begin
					offer(CMD_LOAD, pick_height(style, centre, spread), 0, 0, '0);
					loads++;
				end
			end
			pause_at = $urandom_range(1, SAMPLE_COUNT - 1);
			reads = 0;
			while (reads < SAMPLE_COUNT) begin
				if ($urandom_range(0, NOISE_ODDS - 1) == 0) begin
					offer(CMD_LOAD, $urandom, 0, 0, '0);
				end else begin
					offer(CMD_READ, $urandom, 0, 0, '0);
					reads++;
					if (reads == pause_at) wait_results_drained();
				end
			end
		end

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && tile_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// sink side: random gaps plus two long hold-offs to back the block up
	initial begin : receiver
		int idle, hold_idx;
		int hold_at [2];
		hold_at[0] = 2000;
		hold_at[1] = 14000;
		hold_idx = 0;
		recv_calm = 0;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_idx < 2 && results_seen >= hold_at[hold_idx]) begin
				idle = HOLD_OFF;
				hold_idx++;
			end else begin
				idle = pick_gap(recv_calm);
			end
			if (idle > 0) begin
				result_ch.ready <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
		end
	end

	initial results_seen = 0;

	always @(posedge clk) begin : result_check
		height_result_t got, want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			results_seen++;
			got = {result_ch.kind, result_ch.low_metres, result_ch.high_metres, result_ch.code,
				result_ch.last_of_tile};
			if (tile_results.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_SHOWN)
					$display("[%0t] unexpected result: kind=%0d low=%0d high=%0d code=%0d last=%0d",
						$realtime, got.kind, $signed(got.low_metres), $signed(got.high_metres),
						got.code, got.last_of_tile);
			end else begin
				want = tile_results.pop_front();
				if (got !== want) begin
					fault_count++;
					if (fault_count <= MAX_SHOWN)
						$display({"[%0t] result %0d mismatch: expected kind=%0d low=%0d high=%0d",
							" code=%0d last=%0d, got kind=%0d low=%0d high=%0d code=%0d last=%0d"},
							$realtime, results_seen, want.kind, $signed(want.low_metres),
							$signed(want.high_metres), want.code, want.last_of_tile, got.kind,
							$signed(got.low_metres), $signed(got.high_metres), got.code,
							got.last_of_tile);
				end
			end
		end
	end

	initial begin : watchdog
		int still;
		still = 0;
		while (still < STALL_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
					|| (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
				still = 0;
			else
				still++;
		end
		$display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/thq_pkg.sv
hdl/thq_in_if.sv
hdl/thq_out_if.sv
hdl/thq_ram.sv
hdl/tile_height_quantizer_top.sv
hdl/thq_checker.sv
tb/sv/tb_tile_height_quantizer_top.sv
